// ----- sv/julia_escape_time_pixel_assert.svh -----
// Assertion helpers for the RTL of this block.
`ifndef JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH
`define JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JET_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/jet_pkg.sv -----
`default_nettype none
package jet_pkg;

  localparam int FracBits = 28;
  localparam int PixW     = 10;
  localparam int CountW   = 16;
  localparam int OpW      = 33;
  localparam int ProdW    = 64;
  localparam int SqW      = ProdW - 1 - FracBits;

  localparam logic [CountW-1:0] ColorMod = CountW'(255);
  localparam logic [31:0]       Black    = 32'h0000_0000;

  localparam logic [2:0] RegInvZoom  = 3'd0;
  localparam logic [2:0] RegOffRe    = 3'd1;
  localparam logic [2:0] RegOffIm    = 3'd2;
  localparam logic [2:0] RegConstRe  = 3'd3;
  localparam logic [2:0] RegConstIm  = 3'd4;
  localparam logic [2:0] RegIterLim  = 3'd5;
  localparam logic [2:0] RegColorFac = 3'd6;
  localparam logic [2:0] RegEscBound = 3'd7;

  function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [ProdW-1:0] s;
    s = ProdW'(a) + ProdW'(b);
    return sat32(s);
  endfunction

  function automatic logic [7:0] mod255(input logic [CountW-1:0] v);
    logic [8:0] s;
    s = {1'b0, v[15:8]} + {1'b0, v[7:0]};
    if (s >= ColorMod[8:0]) begin
      s = s - ColorMod[8:0];
    end
    if (s == ColorMod[8:0]) begin
      s = 9'd0;
    end
    return s[7:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/jet_mul.sv -----
`default_nettype none
module jet_mul
  import jet_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic signed [OpW-1:0]   a_i,
  input  wire logic signed [OpW-1:0]   b_i,
  output logic signed [ProdW-1:0]      prod_o
);

  logic signed [2*OpW-1:0] full;
  logic signed [ProdW-1:0] prod_q;

  assign full = a_i * b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= full[ProdW-1:0];
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ----- sv/julia_escape_time_pixel.sv -----
// Julia-set escape-time evaluator for one pixel per transfer. The pixel is mapped to the
// plane as coordinate times inverse_zoom plus offset, then z = z^2 + c is iterated in
// signed Q4.28 with saturation until |z|^2 reaches escape_bound or the counter reaches
// iteration_limit. One registered 33x33 multiplier does all products, three per pass,
// and the input side is ready only while no pixel is in flight. A finished result waits
// in the output register, and the next pixel may be taken while it waits.
`default_nettype none
`include "julia_escape_time_pixel_assert.svh"
module julia_escape_time_pixel
  import jet_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [9:0] pixel_x, [19:10] pixel_y, [23:20] zero
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [9:0] out_x, [19:10] out_y, [51:20] pixel_color, [67:52] escape_count, [71:68] zero
  output logic [71:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAPX = 4'd1;
  localparam logic [3:0] S_MAPY = 4'd2;
  localparam logic [3:0] S_SQX  = 4'd3;
  localparam logic [3:0] S_SQY  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_XY   = 4'd6;
  localparam logic [3:0] S_NX   = 4'd7;
  localparam logic [3:0] S_NY   = 4'd8;
  localparam logic [3:0] S_COL  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [30:0]        inv_zoom_q;
  logic signed [31:0] off_re_q, off_im_q, const_re_q, const_im_q;
  logic [15:0]        iter_lim_q;
  logic [31:0]        color_fac_q, esc_bound_q;

  logic [3:0]         state_q, state_d;
  logic               first_q, first_d;
  logic [PixW-1:0]    px_q, py_q;
  logic signed [31:0] zx_q, zx_d, zy_q, zy_d;
  logic [SqW-1:0]     sqx_q, sqx_d, sqy_q, sqy_d;
  logic [CountW-1:0]  i_q, i_d;

  logic               out_valid_q, out_valid_d;
  logic [PixW-1:0]    out_x_q, out_y_q;
  logic [31:0]        out_color_q;
  logic [CountW-1:0]  out_count_q;
  logic               out_load;

  logic signed [OpW-1:0]   op_a, op_b;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] prod_frac, prod_frac2;
  logic [SqW-1:0]          prod_sq;
  logic [SqW:0]            mag;
  logic                    escaped;
  logic [CountW-1:0]       i_inc;
  logic signed [31:0]      xx, yy;
  logic [7:0]              col_idx;
  logic                    in_xfer, cfg_wr;

  assign pready        = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_wr        = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_zoom_q  <= 31'd268435;
      off_re_q    <= -32'sd536870912;
      off_im_q    <= -32'sd536870912;
      const_re_q  <= -32'sd187904819;
      const_im_q  <= 32'sd725849477;
      iter_lim_q  <= 16'd100;
      color_fac_q <= 32'd65793;
      esc_bound_q <= 32'd1073741824;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        RegInvZoom:  inv_zoom_q  <= pwdata[30:0];
        RegOffRe:    off_re_q    <= pwdata;
        RegOffIm:    off_im_q    <= pwdata;
        RegConstRe:  const_re_q  <= pwdata;
        RegConstIm:  const_im_q  <= pwdata;
        RegIterLim:  iter_lim_q  <= pwdata[15:0];
        RegColorFac: color_fac_q <= pwdata;
        RegEscBound: esc_bound_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegInvZoom:  prdata = {1'b0, inv_zoom_q};
      RegOffRe:    prdata = off_re_q;
      RegOffIm:    prdata = off_im_q;
      RegConstRe:  prdata = const_re_q;
      RegConstIm:  prdata = const_im_q;
      RegIterLim:  prdata = {16'd0, iter_lim_q};
      RegColorFac: prdata = color_fac_q;
      RegEscBound: prdata = esc_bound_q;
      default:     prdata = 32'd0;
    endcase
  end

  always_comb begin
    unique case (state_q)
      S_MAPX: begin
        op_a = OpW'({1'b0, px_q});
        op_b = OpW'({1'b0, inv_zoom_q});
      end
      S_MAPY: begin
        op_a = OpW'({1'b0, py_q});
        op_b = OpW'({1'b0, inv_zoom_q});
      end
      S_SQX, S_NX: begin
        op_a = OpW'(zx_d);
        op_b = OpW'(zx_d);
      end
      S_SQY, S_NY: begin
        op_a = OpW'(zy_d);
        op_b = OpW'(zy_d);
      end
      S_XY: begin
        op_a = OpW'(zx_q);
        op_b = OpW'(zy_q);
      end
      S_COL, S_OUT: begin
        op_a = OpW'({1'b0, color_fac_q});
        op_b = OpW'({1'b0, col_idx});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  jet_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  assign prod_frac  = prod >>> FracBits;
  assign prod_frac2 = prod >>> (FracBits - 1);
  assign prod_sq    = prod_frac[SqW-1:0];
  assign mag        = {1'b0, sqx_q} + {1'b0, prod_sq};
  assign escaped    = !first_q && (mag >= (SqW+1)'(esc_bound_q));
  assign i_inc      = first_q ? i_q : (i_q + CountW'(1));
  assign xx         = sat32(ProdW'(sqx_q));
  assign yy         = sat32(ProdW'(sqy_q));
  assign col_idx    = mod255(i_q);

  always_comb begin
    state_d = state_q;
    first_d = first_q;
    zx_d    = zx_q;
    zy_d    = zy_q;
    sqx_d   = sqx_q;
    sqy_d   = sqy_q;
    i_d     = i_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_MAPX;
        end
      end
      S_MAPX: state_d = S_MAPY;
      S_MAPY: begin
        zx_d    = sat_add(sat32(prod), off_re_q);
        state_d = S_SQX;
      end
      S_SQX: begin
        zy_d    = sat_add(sat32(prod), off_im_q);
        state_d = S_SQY;
      end
      S_SQY: begin
        sqx_d   = prod_sq;
        state_d = S_CHK;
      end
      S_CHK: begin
        sqy_d = prod_sq;
        if (escaped) begin
          state_d = S_COL;
        end else begin
          i_d = i_inc;
          if (i_inc < iter_lim_q) begin
            state_d = S_XY;
          end else begin
            state_d = S_COL;
          end
        end
        first_d = 1'b0;
      end
      S_XY: begin
        zx_d    = sat_add(sat32(ProdW'(xx) - ProdW'(yy)), const_re_q);
        state_d = S_NX;
      end
      S_NX: begin
        zy_d    = sat_add(sat32(prod_frac2), const_im_q);
        state_d = S_NY;
      end
      S_NY: begin
        sqx_d   = prod_sq;
        state_d = S_CHK;
      end
      S_COL: state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (in_xfer) begin
      first_d = 1'b1;
      i_d     = CountW'(1);
    end
  end

  assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    zx_q    <= zx_d;
    zy_q    <= zy_d;
    sqx_q   <= sqx_d;
    sqy_q   <= sqy_d;
    i_q     <= i_d;
    if (in_xfer) begin
      px_q <= s_axis_tdata[9:0];
      py_q <= s_axis_tdata[19:10];
    end
    if (out_load) begin
      out_x_q     <= px_q;
      out_y_q     <= py_q;
      out_count_q <= i_q;
      out_color_q <= (i_q == iter_lim_q) ? Black : prod[31:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_count_q, out_color_q, out_y_q, out_x_q};

  `JET_ASSERT_NEXT(a_start_map, in_xfer, state_q == S_MAPX, "input transfer did not start mapping")
  `JET_ASSERT_NEXT(a_pass_order, state_q == S_XY, state_q == S_NX, "iteration pass out of order")
  `JET_ASSERT_NEXT(a_out_hold, (state_q == S_OUT) && out_valid_q && !m_axis_tready, state_q == S_OUT, "result dropped while output stalled")
  `JET_ASSERT_SAME(a_busy_not_ready, state_q != S_IDLE, !s_axis_tready, "input ready while a pixel is in flight")

endmodule
`default_nettype wire

// ----- tb/sv/julia_escape_time_pixel_tb.sv -----
`timescale 1ns / 1ps
module julia_escape_time_pixel_tb;
  import jet_pkg::*;

  localparam int          GAP_PCT      = 7;
  localparam int          SETTLE_CYCLES = 16;
  localparam int unsigned TIMEOUT_NS   = 50_000_000;
  localparam int unsigned COLOR_WRAP   = 255;
  localparam logic [31:0] INSIDE_COLOR = 32'h0000_0000;

  typedef struct {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [31:0] color;
    logic [15:0] count;
  } pixel_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [30:0] inv_zoom_q    = 31'd268435;
  int          off_re_q      = -536870912;
  int          off_im_q      = -536870912;
  int          const_re_q    = -187904819;
  int          const_im_q    = 725849477;
  logic [15:0] iter_limit_q  = 16'd100;
  logic [31:0] color_fac_q   = 32'd65793;
  logic [31:0] esc_bound_q   = 32'd1073741824;

  pixel_result_t pending_pixels[$];
  int            error_count   = 0;
  int            pixels_sent   = 0;
  int            results_seen  = 0;
  int            setting_count = 0;
  bit            no_gaps       = 1'b0;

  julia_escape_time_pixel u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic int clamp_s32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return int'(v);
  endfunction

  function automatic pixel_result_t predict_pixel(input logic [9:0] px, input logic [9:0] py);
    pixel_result_t r;
    int          zx;
    int          zy;
    int          xx;
    int          yy;
    int          xy2;
    int          nx;
    int          ny;
    longint      mag;
    int unsigned i;
    zx = clamp_s32(longint'(clamp_s32(longint'(px) * longint'(inv_zoom_q)))
                   + longint'(off_re_q));
    zy = clamp_s32(longint'(clamp_s32(longint'(py) * longint'(inv_zoom_q)))
                   + longint'(off_im_q));
    i = 1;
    while (i < iter_limit_q) begin
      xx  = clamp_s32((longint'(zx) * longint'(zx)) >>> FracBits);
      yy  = clamp_s32((longint'(zy) * longint'(zy)) >>> FracBits);
      xy2 = clamp_s32((longint'(zx) * longint'(zy)) >>> (FracBits - 1));
      nx  = clamp_s32(longint'(clamp_s32(longint'(xx) - longint'(yy))) + longint'(const_re_q));
      ny  = clamp_s32(longint'(xy2) + longint'(const_im_q));
      zx  = nx;
      zy  = ny;
      mag = ((longint'(zx) * longint'(zx)) >>> FracBits)
            + ((longint'(zy) * longint'(zy)) >>> FracBits);
      if (mag >= longint'(esc_bound_q)) begin
        break;
      end
      i++;
    end
    r.x     = px;
    r.y     = py;
    r.color = (i == iter_limit_q) ? INSIDE_COLOR : color_fac_q * 32'(i % COLOR_WRAP);
    r.count = i[15:0];
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegInvZoom:  inv_zoom_q   = value[30:0];
      RegOffRe:    off_re_q     = int'(value);
      RegOffIm:    off_im_q     = int'(value);
      RegConstRe:  const_re_q   = int'(value);
      RegConstIm:  const_im_q   = int'(value);
      RegIterLim:  iter_limit_q = value[15:0];
      RegColorFac: color_fac_q  = value;
      RegEscBound: esc_bound_q  = value;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [31:0] inv_zoom, input logic [31:0] off_re,
                               input logic [31:0] off_im, input logic [31:0] c_re,
                               input logic [31:0] c_im, input logic [31:0] limit,
                               input logic [31:0] factor, input logic [31:0] bound);
    write_reg(RegInvZoom, inv_zoom);
    write_reg(RegOffRe, off_re);
    write_reg(RegOffIm, off_im);
    write_reg(RegConstRe, c_re);
    write_reg(RegConstIm, c_im);
    write_reg(RegIterLim, limit);
    write_reg(RegColorFac, factor);
    write_reg(RegEscBound, bound);
    setting_count++;
  endtask

  task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
    if (!no_gaps && $urandom_range(99) < GAP_PCT) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tdata  <= {4'b0000, py, px};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_pixels.push_back(predict_pixel(px, py));
    pixels_sent++;
  endtask

  task automatic wait_results_done;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
  end

  always @(posedge clk_i) begin : check_results
    pixel_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual 0x%0h",
                 $time, m_axis_tdata);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("out_x", want.x, m_axis_tdata[9:0]);
        check_field("out_y", want.y, m_axis_tdata[19:10]);
        check_field("pixel_color", want.color, m_axis_tdata[51:20]);
        check_field("escape_count", want.count, m_axis_tdata[67:52]);
      end
    end
  end

  task automatic test_reset_values;
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd512, 10'd300);
    wait_results_done();
  endtask

  task automatic test_limit_edges;
    write_reg(RegIterLim, 32'd0);
    send_pixel(10'd1, 10'd2);
    send_pixel(10'd1023, 10'd1023);
    wait_results_done();
    write_reg(RegIterLim, 32'd1);
    send_pixel(10'd700, 10'd20);
    send_pixel(10'd0, 10'd0);
    wait_results_done();
    write_reg(RegIterLim, 32'd65535);
    write_reg(RegEscBound, 32'd0);
    send_pixel(10'd333, 10'd777);
    send_pixel(10'd1023, 10'd0);
    wait_results_done();
    setting_count += 3;
  endtask

  task automatic test_saturation;
    load_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'd12, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd1023);
    wait_results_done();
    load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'd16, 32'hFFFF_FFFF, 32'd1);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd1, 10'd1);
    wait_results_done();
  endtask

  task automatic test_zero_plane;
    load_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd20, 32'd0, 32'h1000_0000);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd341, 10'd682);
    wait_results_done();
  endtask

  task automatic test_random_pixels;
    int items;
    int limit;
    for (int phase = 0; phase < 8; phase++) begin
      items = (phase == 2) ? 40 : 115;
      if (phase == 3 || phase == 6) begin
        load_settings($urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(1, 48), $urandom, $urandom);
      end else begin
        limit = (phase == 2) ? $urandom_range(256, 300) : $urandom_range(2, 64);
        load_settings($urandom_range(1 << 19, 1 << 21),
                      int'($urandom_range(0, 1 << 27)) - (1 << 29) - (1 << 26),
                      int'($urandom_range(0, 1 << 27)) - (1 << 29) - (1 << 26),
                      int'($urandom_range(0, 1 << 29)) - (1 << 28),
                      int'($urandom_range(0, 1 << 29)) - (1 << 28),
                      limit, $urandom,
                      ($urandom_range(1)) ? 32'h4000_0000 : $urandom_range(1 << 28, 1 << 31));
      end
      no_gaps = (phase == 4);
      for (int n = 0; n < items; n++) begin
        if (phase == 5 && n == 50) begin
          wait_results_done();
        end
        send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
      end
      wait_results_done();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_limit_edges();
    test_saturation();
    test_zero_plane();
    test_random_pixels();
    wait_results_done();
    $display("Ran %0d pixels through %0d register settings and checked %0d results.",
             pixels_sent, setting_count, results_seen);
    $display("Settings spanned limits 0 to 65535, saturating maps and random Julia constants.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: run did not finish, %0d results still expected",
             $time, pending_pixels.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/jet_pkg.sv
sv/jet_mul.sv
sv/julia_escape_time_pixel.sv
tb/sv/julia_escape_time_pixel_tb.sv
